// ----- sv/pcrc_pkg.sv -----
// Package for the per-color reachability counter: sizes, codes and index helpers.
// No dependencies; used by the interfaces, the top level and the bench.
`default_nettype none
package pcrc_pkg;

    localparam int NODES   = 64;
    localparam int COLORS  = 64;

    localparam int FIELD_W = 6;
    localparam int COUNT_W = 7;
    localparam int LABEL_W = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int COLOR_W = (COLORS > 1) ? $clog2(COLORS) : 1;
    localparam int ADDR_W  = COLOR_W + LABEL_W;
    localparam int RAM_DEPTH = 1 << ADDR_W;

    localparam logic [COUNT_W-1:0] COUNT_MAX  = {COUNT_W{1'b1}};
    localparam logic [LABEL_W-1:0] LAST_NODE  = LABEL_W'(NODES - 1);
    localparam logic [COLOR_W-1:0] LAST_COLOR = COLOR_W'(COLORS - 1);

    typedef logic [FIELD_W-1:0] field_t;
    typedef logic [LABEL_W-1:0] label_t;
    typedef logic [COLOR_W-1:0] color_t;
    typedef logic [ADDR_W-1:0]  addr_t;
    typedef logic [COUNT_W-1:0] count_t;

    typedef enum logic {
        OP_ADD_EDGE = 1'b0,
        OP_QUERY    = 1'b1
    } op_t;

    function automatic label_t to_label(input field_t f);
        logic [15:0] w;
        w = 16'(f);
        return w[LABEL_W-1:0];
    endfunction

    function automatic color_t to_color(input field_t f);
        logic [15:0] w;
        w = 16'(f);
        return w[COLOR_W-1:0];
    endfunction

    function automatic logic node_ok(input field_t f);
        return 16'(f) < 16'(NODES);
    endfunction

    function automatic logic color_ok(input field_t f);
        return 16'(f) < 16'(COLORS);
    endfunction

endpackage
`default_nettype wire

// ----- sv/pcrc_if.sv -----
// Valid/ready channel interfaces for requests and results.
// Depends on pcrc_pkg for field types.
`default_nettype none
interface pcrc_req_if;
    import pcrc_pkg::*;
    logic   valid;
    logic   ready;
    logic   op;
    field_t node_a;
    field_t node_b;
    field_t edge_color;
    modport source (output valid, output op, output node_a, output node_b,
                    output edge_color, input ready);
    modport sink   (input valid, input op, input node_a, input node_b,
                    input edge_color, output ready);
endinterface

interface pcrc_rsp_if;
    import pcrc_pkg::*;
    logic   valid;
    logic   ready;
    count_t color_count;
    modport source (output valid, output color_count, input ready);
    modport sink   (input valid, input color_count, output ready);
endinterface
`default_nettype wire

// ----- sv/per_color_reachability_count.sv -----
// Per-color reachability counter: label RAM indexed by {color, node}.
// Add edge: reads both endpoint labels, then rewrites the color row one node per cycle.
// Query: one color per cycle, two RAM reads; the next request is accepted as the result
// goes valid, and a waiting result holds the query in its last state.
// rst_n clears control and the seen-color flags; the label RAM is not cleared,
// a color row is written in full on its first edge and reads as identity until then.
// Depends on pcrc_pkg, pcrc_if and pcrc_ram.
`default_nettype none
module per_color_reachability_count (
    input  wire logic  clk,
    input  wire logic  rst_n,
    pcrc_req_if.sink   request,
    pcrc_rsp_if.source result
);
    import pcrc_pkg::*;

    typedef enum logic [2:0] {
        IDLE,
        M_READ,
        M_KEY,
        M_SWEEP,
        M_DRAIN,
        Q_SCAN,
        Q_LAST,
        Q_DONE
    } state_t;

    state_t              state_reg;
    label_t              a_reg;
    label_t              b_reg;
    color_t              color_reg;
    logic                same_reg;
    logic                in_range_reg;
    logic                row_valid_reg;
    label_t              keep_reg;
    label_t              drop_reg;
    label_t              node_idx_reg;
    label_t              wr_node_reg;
    logic                wr_pend_reg;
    color_t              scan_reg;
    color_t              cmp_color_reg;
    logic                cmp_pend_reg;
    count_t              count_reg;
    logic [COLORS-1:0]   seen_reg;
    logic                out_valid_reg;
    count_t              out_count_reg;

    addr_t               raddr0;
    addr_t               raddr1;
    label_t              rdata0;
    label_t              rdata1;
    label_t              old_label;
    label_t              new_label;
    logic                hit;
    count_t              count_next;
    logic                out_free;

    assign request.ready      = (state_reg == IDLE);
    assign result.valid       = out_valid_reg;
    assign result.color_count = out_count_reg;
    assign out_free           = !out_valid_reg || result.ready;

    always_comb
    begin
        unique case (state_reg)
            M_READ:
            begin
                raddr0 = {color_reg, a_reg};
                raddr1 = {color_reg, b_reg};
            end
            M_SWEEP:
            begin
                raddr0 = {color_reg, node_idx_reg};
                raddr1 = {color_reg, node_idx_reg};
            end
            default:
            begin
                raddr0 = {scan_reg, a_reg};
                raddr1 = {scan_reg, b_reg};
            end
        endcase
    end

    assign old_label = row_valid_reg ? rdata0 : wr_node_reg;
    assign new_label = (old_label == drop_reg) ? keep_reg : old_label;

    assign hit = seen_reg[cmp_color_reg] &&
                 (same_reg || (in_range_reg && (rdata0 == rdata1)));
    assign count_next = (state_reg == IDLE) ? '0 :
                        (cmp_pend_reg && hit && (count_reg != COUNT_MAX)) ?
                        count_reg + 1'b1 : count_reg;

    pcrc_ram #(
        .WIDTH (LABEL_W),
        .DEPTH (RAM_DEPTH)
    ) u_labels (
        .clk    (clk),
        .we     (wr_pend_reg),
        .waddr  ({color_reg, wr_node_reg}),
        .wdata  (new_label),
        .raddr0 (raddr0),
        .rdata0 (rdata0),
        .raddr1 (raddr1),
        .rdata1 (rdata1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= IDLE;
            a_reg         <= '0;
            b_reg         <= '0;
            color_reg     <= '0;
            same_reg      <= 1'b0;
            in_range_reg  <= 1'b0;
            row_valid_reg <= 1'b0;
            keep_reg      <= '0;
            drop_reg      <= '0;
            node_idx_reg  <= '0;
            wr_node_reg   <= '0;
            wr_pend_reg   <= 1'b0;
            scan_reg      <= '0;
            cmp_color_reg <= '0;
            cmp_pend_reg  <= 1'b0;
            count_reg     <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
            out_count_reg <= '0;
        end
        else
        begin
            out_valid_reg <= ((state_reg == Q_DONE) && out_free) ||
                             (out_valid_reg && !result.ready);
            wr_pend_reg   <= (state_reg == M_SWEEP);
            wr_node_reg   <= node_idx_reg;
            cmp_pend_reg  <= (state_reg == Q_SCAN);
            cmp_color_reg <= scan_reg;
            count_reg     <= count_next;

            unique case (state_reg)
                IDLE:
                begin
                    if (request.valid)
                    begin
                        a_reg        <= to_label(request.node_a);
                        b_reg        <= to_label(request.node_b);
                        color_reg    <= to_color(request.edge_color);
                        same_reg     <= (request.node_a == request.node_b);
                        in_range_reg <= node_ok(request.node_a) && node_ok(request.node_b);
                        scan_reg     <= '0;
                        if (op_t'(request.op) == OP_QUERY)
                        begin
                            state_reg <= Q_SCAN;
                        end
                        else if (node_ok(request.node_a) && node_ok(request.node_b) &&
                                 color_ok(request.edge_color))
                        begin
                            row_valid_reg <= seen_reg[to_color(request.edge_color)];
                            seen_reg[to_color(request.edge_color)] <= 1'b1;
                            state_reg <= M_READ;
                        end
                    end
                end
                M_READ:
                begin
                    state_reg <= M_KEY;
                end
                M_KEY:
                begin
                    keep_reg     <= row_valid_reg ? rdata0 : a_reg;
                    drop_reg     <= row_valid_reg ? rdata1 : b_reg;
                    node_idx_reg <= '0;
                    state_reg    <= M_SWEEP;
                end
                M_SWEEP:
                begin
                    node_idx_reg <= node_idx_reg + 1'b1;
                    if (node_idx_reg == LAST_NODE)
                    begin
                        state_reg <= M_DRAIN;
                    end
                end
                M_DRAIN:
                begin
                    state_reg <= IDLE;
                end
                Q_SCAN:
                begin
                    scan_reg <= scan_reg + 1'b1;
                    if (scan_reg == LAST_COLOR)
                    begin
                        state_reg <= Q_LAST;
                    end
                end
                Q_LAST:
                begin
                    state_reg <= Q_DONE;
                end
                Q_DONE:
                begin
                    if (out_free)
                    begin
                        out_count_reg <= count_reg;
                        state_reg     <= IDLE;
                    end
                end
                default:
                begin
                    state_reg <= IDLE;
                end
            endcase
        end
    end

endmodule
`default_nettype wire

// ----- sv/pcrc_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
`default_nettype none
module pcrc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr0,
    output logic      [WIDTH-1:0]         rdata0,
    input  wire logic [$clog2(DEPTH)-1:0] raddr1,
    output logic      [WIDTH-1:0]         rdata1
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end

endmodule
`default_nettype wire

// ----- bench/per_color_reachability_count_test.sv -----
`timescale 1ns / 100ps
// Self-checking bench for per_color_reachability_count: directed table, then biased random
// edge/query traffic; counts the table does not fix are checked against an in-bench label predictor.
// Depends on pcrc_pkg, pcrc_if and the RTL top level.
module per_color_reachability_count_test;
    import pcrc_pkg::*;

    localparam int RANDOM_REQUESTS = 350;
    localparam int STALL_LIMIT     = 2000;
    localparam int DRAIN_CYCLES    = 80;
    localparam int DIRECTED_COUNT  = 23;
    localparam int EXPECT_DEPTH    = 1024;

    typedef struct packed {
        op_t    op;
        field_t a;
        field_t b;
        field_t c;
        logic   typed;
        count_t want;
    } step_t;

    localparam step_t DIRECTED_STEPS [DIRECTED_COUNT] = '{
        '{OP_QUERY,    6'd0,  6'd0,  6'd0,  1'b1, 7'd0},
        '{OP_QUERY,    6'd63, 6'd0,  6'd63, 1'b1, 7'd0},
        '{OP_ADD_EDGE, 6'd5,  6'd5,  6'd0,  1'b0, 7'd0},  // self edge: seen, no merge
        '{OP_QUERY,    6'd5,  6'd5,  6'd0,  1'b1, 7'd1},
        '{OP_QUERY,    6'd5,  6'd6,  6'd0,  1'b1, 7'd0},
        '{OP_ADD_EDGE, 6'd0,  6'd63, 6'd63, 1'b0, 7'd0},
        '{OP_QUERY,    6'd0,  6'd63, 6'd0,  1'b1, 7'd1},
        '{OP_QUERY,    6'd63, 6'd0,  6'd63, 1'b1, 7'd1},
        '{OP_ADD_EDGE, 6'd63, 6'd0,  6'd63, 1'b0, 7'd0},  // repeated edge
        '{OP_QUERY,    6'd63, 6'd63, 6'd63, 1'b1, 7'd2},
        '{OP_ADD_EDGE, 6'd1,  6'd2,  6'd1,  1'b0, 7'd0},
        '{OP_ADD_EDGE, 6'd2,  6'd3,  6'd1,  1'b0, 7'd0},
        '{OP_ADD_EDGE, 6'd3,  6'd1,  6'd1,  1'b0, 7'd0},  // edge inside one component
        '{OP_QUERY,    6'd1,  6'd3,  6'd42, 1'b0, 7'd0},
        '{OP_ADD_EDGE, 6'd10, 6'd11, 6'd2,  1'b0, 7'd0},
        '{OP_ADD_EDGE, 6'd12, 6'd13, 6'd2,  1'b0, 7'd0},
        '{OP_QUERY,    6'd10, 6'd13, 6'd2,  1'b0, 7'd0},
        '{OP_ADD_EDGE, 6'd11, 6'd12, 6'd2,  1'b0, 7'd0},  // joins two components
        '{OP_QUERY,    6'd13, 6'd10, 6'd2,  1'b0, 7'd0},
        '{OP_ADD_EDGE, 6'd42, 6'd21, 6'd21, 1'b0, 7'd0},
        '{OP_ADD_EDGE, 6'd21, 6'd42, 6'd42, 1'b0, 7'd0},
        '{OP_QUERY,    6'd42, 6'd21, 6'd0,  1'b0, 7'd0},
        '{OP_QUERY,    6'd62, 6'd61, 6'd0,  1'b0, 7'd0}
    };

    logic clk;
    logic rst_n;
    logic gaps_on;

    pcrc_req_if req_ch ();
    pcrc_rsp_if rsp_ch ();

    per_color_reachability_count DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .result  (rsp_ch)
    );

    label_t reach_label [COLORS][NODES];
    logic   color_live  [COLORS];
    count_t expected_counts [EXPECT_DEPTH];

    int exp_wr       = 0;
    int exp_rd       = 0;
    int error_count  = 0;
    int adds_sent    = 0;
    int queries_sent = 0;
    int results_seen = 0;
    int stall_cycles = 0;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    task automatic clear_labels();
        for (int c = 0; c < COLORS; c++)
        begin
            color_live[c] = 1'b0;
            for (int n = 0; n < NODES; n++)
                reach_label[c][n] = label_t'(n);
        end
    endtask

    function automatic void merge_edge(input field_t a, input field_t b, input field_t c);
        label_t keep;
        label_t drop;
        if (int'(a) >= NODES || int'(b) >= NODES || int'(c) >= COLORS)
            return;
        color_live[c] = 1'b1;
        keep = reach_label[c][a];
        drop = reach_label[c][b];
        if (keep == drop)
            return;
        for (int n = 0; n < NODES; n++)
            if (reach_label[c][n] == drop)
                reach_label[c][n] = keep;
    endfunction

    function automatic count_t count_linking_colors(input field_t a, input field_t b);
        int  total;
        logic both_ok;
        total   = 0;
        both_ok = (int'(a) < NODES) && (int'(b) < NODES);
        for (int c = 0; c < COLORS; c++)
            if (color_live[c] &&
                (a == b || (both_ok && reach_label[c][a] == reach_label[c][b])))
                if (total < int'(COUNT_MAX))
                    total++;
        return count_t'(total);
    endfunction

    task automatic send_request(input op_t op, input field_t a, input field_t b,
                                input field_t c, input logic typed, input count_t want);
        while (gaps_on && $urandom_range(99) < 10)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.op         <= op;
        req_ch.node_a     <= a;
        req_ch.node_b     <= b;
        req_ch.edge_color <= c;
        @(posedge clk);
        while (req_ch.ready !== 1'b1)
            @(posedge clk);
        if (op == OP_ADD_EDGE)
        begin
            adds_sent++;
            merge_edge(a, b, c);
        end
        else
        begin
            queries_sent++;
            expected_counts[exp_wr] = typed ? want : count_linking_colors(a, b);
            exp_wr++;
        end
    endtask

    function automatic field_t pick_node();
        int r;
        r = $urandom_range(99);
        if (r < 45)
            return field_t'($urandom_range(15));
        else if (r < 80)
            return field_t'($urandom_range(63, 48));
        return field_t'($urandom_range(63));
    endfunction

    task automatic random_request();
        int     r;
        field_t a;
        field_t b;
        field_t c;
        r = $urandom_range(99);
        a = pick_node();
        b = pick_node();
        c = ($urandom_range(99) < 75) ? field_t'($urandom_range(7)) : field_t'($urandom_range(63));
        if (r < 10)
            send_request(op_t'($urandom_range(1)), field_t'($urandom_range(63)),
                         field_t'($urandom_range(63)), field_t'($urandom_range(63)), 1'b0, '0);
        else if (r < 60)
            send_request(OP_ADD_EDGE, a, b, c, 1'b0, '0);
        else if (r < 68)
            send_request(OP_QUERY, a, a, c, 1'b0, '0);
        else
            send_request(OP_QUERY, a, b, c, 1'b0, '0);
    endtask

    // result side: random backpressure and in-order compare
    always @(posedge clk)
    begin
        count_t want;
        if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)
        begin
            results_seen++;
            if (exp_rd == exp_wr)
            begin
                $display("%0t: color_count expected none, got %0d", $time, rsp_ch.color_count);
                error_count++;
            end
            else
            begin
                want = expected_counts[exp_rd];
                exp_rd++;
                if (rsp_ch.color_count !== want)
                begin
                    $display("%0t: color_count expected %0d, got %0d",
                             $time, want, rsp_ch.color_count);
                    error_count++;
                end
            end
        end
        rsp_ch.ready <= !(gaps_on && $urandom_range(99) < 10);
    end

    always @(posedge clk)
    begin
        if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
            (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
            stall_cycles <= 0;
        else if (rst_n === 1'b1)
        begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        field_t a;
        rst_n             = 1'b0;
        gaps_on           = 1'b1;
        req_ch.valid      = 1'b0;
        req_ch.op         = OP_ADD_EDGE;
        req_ch.node_a     = '0;
        req_ch.node_b     = '0;
        req_ch.edge_color = '0;
        clear_labels();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIRECTED_COUNT; i++)
            send_request(DIRECTED_STEPS[i].op, DIRECTED_STEPS[i].a, DIRECTED_STEPS[i].b,
                         DIRECTED_STEPS[i].c, DIRECTED_STEPS[i].typed,
                         DIRECTED_STEPS[i].want);

        for (int i = 0; i < RANDOM_REQUESTS; i++)
        begin
            gaps_on <= !(i >= 150 && i < 260);
            random_request();
        end

        // mark every color seen so a same-node query reaches the full count
        gaps_on <= 1'b1;
        for (int c = 0; c < COLORS; c++)
            send_request(OP_ADD_EDGE, field_t'(c), field_t'(NODES - 1 - c), field_t'(c),
                         1'b0, '0);
        for (int i = 0; i < 8; i++)
        begin
            a = pick_node();
            send_request(OP_QUERY, a, a, field_t'($urandom_range(63)), 1'b0, '0);
            send_request(OP_QUERY, a, pick_node(), field_t'($urandom_range(63)), 1'b0, '0);
        end
        req_ch.valid <= 1'b0;

        while (exp_rd != exp_wr)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d edge adds and %0d queries, %0d counts checked",
                 adds_sent, queries_sent, results_seen);
        $display("traffic: directed corner cases, clustered random graphs, all colors seen");
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

// ----- per_color_reachability_count.f -----
sv/pcrc_pkg.sv
sv/pcrc_if.sv
sv/pcrc_ram.sv
sv/per_color_reachability_count.sv
bench/per_color_reachability_count_test.sv
